FILE: sv/lzwst_pkg.sv
// ============================================================================
// lzwst_pkg: shared types and constants of the LZW string table
// Field widths, table and stack sizes, mode/status/command codes.
// ============================================================================
package lzwst_pkg;

    // Table and string limits
    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_LEN     = 64;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int CODE_W   = 12;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LINK_W   = CODE_W + 1;
    localparam int STACK_AW = $clog2(MAX_LEN);
    localparam int DEPTH_W  = $clog2(MAX_LEN + 1);

    // Input modes
    localparam logic [MODE_W-1:0] MODE_ROOT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXTEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUFFIX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd3;

    // Classified commands from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_ROOT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXTEND   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUFFIX   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR_FULL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERR_CODE = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] value;
        logic [CODE_W-1:0] new_code;
    } cmd_t;

endpackage

FILE: sv/lzwst_ram.sv
// ============================================================================
// lzwst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module lzwst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write when enabled; read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/lzwst_front.sv
// ============================================================================
// lzwst_front: request intake and classification
// Checks codes against the allocation count, assigns new codes, and queues
// a classified command for the back end.
// ============================================================================
module lzwst_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lzwst_pkg::MODE_W-1:0]   mode,
    input  logic [lzwst_pkg::CODE_W-1:0]   code,
    input  logic [lzwst_pkg::BYTE_W-1:0]   byte_value,
    input  logic                           q_full,
    output logic                           q_push,
    output lzwst_pkg::cmd_t                q_cmd
);

    logic [lzwst_pkg::COUNT_W-1:0] next_free_reg;
    logic [lzwst_pkg::COUNT_W-1:0] next_free_next;
    logic                          known;
    logic                          table_full;
    logic                          alloc;

    assign in_stall   = q_full;
    assign q_push     = in_valid && !q_full;
    assign known      = lzwst_pkg::COUNT_W'(code) < next_free_reg;
    assign table_full = next_free_reg == lzwst_pkg::COUNT_W'(lzwst_pkg::TABLE_DEPTH);

    // Classify the request; unknown code wins over a full table
    always_comb
    begin
        q_cmd.code     = code;
        q_cmd.value    = byte_value;
        q_cmd.new_code = next_free_reg[lzwst_pkg::CODE_W-1:0];
        alloc          = 1'b0;
        unique case (mode)
            lzwst_pkg::MODE_ROOT:
            begin
                q_cmd.kind = table_full ? lzwst_pkg::KIND_ERR_FULL : lzwst_pkg::KIND_ROOT;
                alloc      = !table_full;
            end
            lzwst_pkg::MODE_EXTEND:
            begin
                if (!known)
                begin
                    q_cmd.kind = lzwst_pkg::KIND_ERR_CODE;
                end
                else if (table_full)
                begin
                    q_cmd.kind = lzwst_pkg::KIND_ERR_FULL;
                end
                else
                begin
                    q_cmd.kind = lzwst_pkg::KIND_EXTEND;
                    alloc      = 1'b1;
                end
            end
            lzwst_pkg::MODE_SUFFIX:
            begin
                q_cmd.kind = known ? lzwst_pkg::KIND_SUFFIX : lzwst_pkg::KIND_ERR_CODE;
            end
            lzwst_pkg::MODE_READ:
            begin
                q_cmd.kind = known ? lzwst_pkg::KIND_READ : lzwst_pkg::KIND_ERR_CODE;
            end
        endcase
    end

    // Advance the allocation count on an accepted new entry
    assign next_free_next = (q_push && alloc) ?
                            next_free_reg + lzwst_pkg::COUNT_W'(1) : next_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
        end
        else
        begin
            next_free_reg <= next_free_next;
        end
    end

endmodule

FILE: sv/lzwst_queue.sv
// ============================================================================
// lzwst_queue: two-entry command queue
// Decouples request intake from table execution.
// ============================================================================
module lzwst_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lzwst_pkg::cmd_t cmd_in,
    input  logic            pop,
    output lzwst_pkg::cmd_t cmd_out,
    output logic            empty,
    output logic            full
);

    lzwst_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign empty   = count_reg == 2'd0;
    assign full    = count_reg == 2'd2;
    assign cmd_out = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: sv/lzwst_back.sv
// ============================================================================
// lzwst_back: table execution and result output
// Writes the suffix and prefix tables, walks prefix chains onto a LIFO,
// pops string bytes, and holds results in an output register.
// ============================================================================
module lzwst_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  lzwst_pkg::cmd_t                 q_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lzwst_pkg::CODE_W-1:0]    new_code,
    output logic [lzwst_pkg::BYTE_W-1:0]    byte_out,
    output logic [lzwst_pkg::POS_W-1:0]     position,
    output logic                            last,
    output logic [lzwst_pkg::STATUS_W-1:0]  status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_LONG = 3'd4;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [lzwst_pkg::DEPTH_W-1:0]     depth_reg;
    logic [lzwst_pkg::DEPTH_W-1:0]     depth_next;
    logic [lzwst_pkg::DEPTH_W-1:0]     depth_m1;
    logic [lzwst_pkg::STACK_AW-1:0]    ptr_reg;
    logic [lzwst_pkg::STACK_AW-1:0]    ptr_next;
    logic [lzwst_pkg::STACK_AW-1:0]    pos_reg;
    logic [lzwst_pkg::STACK_AW-1:0]    pos_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [lzwst_pkg::CODE_W-1:0]      new_code_reg;
    logic [lzwst_pkg::BYTE_W-1:0]      byte_reg;
    logic [lzwst_pkg::POS_W-1:0]       pos_out_reg;
    logic                              last_reg;
    logic [lzwst_pkg::STATUS_W-1:0]    status_reg;
    logic                              out_free;
    logic                              load;
    logic [lzwst_pkg::CODE_W-1:0]      o_new_code;
    logic [lzwst_pkg::BYTE_W-1:0]      o_byte;
    logic [lzwst_pkg::POS_W-1:0]       o_pos;
    logic                              o_last;
    logic [lzwst_pkg::STATUS_W-1:0]    o_status;

    logic                              suf_wr_en;
    logic [lzwst_pkg::ADDR_W-1:0]      suf_wr_addr;
    logic [lzwst_pkg::BYTE_W-1:0]      suf_wr_data;
    logic [lzwst_pkg::BYTE_W-1:0]      suf_rd;
    logic                              pre_wr_en;
    logic [lzwst_pkg::LINK_W-1:0]      pre_wr_data;
    logic [lzwst_pkg::LINK_W-1:0]      pre_rd;
    logic [lzwst_pkg::ADDR_W-1:0]      tab_rd_addr;
    logic                              stk_wr_en;
    logic [lzwst_pkg::STACK_AW-1:0]    stk_rd_addr;
    logic [lzwst_pkg::BYTE_W-1:0]      stk_rd;

    assign out_free = !out_valid_reg || !out_stall;
    assign depth_m1 = depth_reg - lzwst_pkg::DEPTH_W'(1);

    // Follow the link while walking, else look at the queued code
    assign tab_rd_addr = (state_reg == S_WALK) ? pre_rd[lzwst_pkg::ADDR_W-1:0]
                                               : q_cmd.code[lzwst_pkg::ADDR_W-1:0];

    lzwst_ram #(
        .WIDTH (lzwst_pkg::BYTE_W),
        .DEPTH (lzwst_pkg::TABLE_DEPTH)
    ) u_suffix (
        .clk     (clk),
        .wr_en   (suf_wr_en),
        .wr_addr (suf_wr_addr),
        .wr_data (suf_wr_data),
        .rd_addr (tab_rd_addr),
        .rd_data (suf_rd)
    );

    lzwst_ram #(
        .WIDTH (lzwst_pkg::LINK_W),
        .DEPTH (lzwst_pkg::TABLE_DEPTH)
    ) u_prefix (
        .clk     (clk),
        .wr_en   (pre_wr_en),
        .wr_addr (q_cmd.new_code[lzwst_pkg::ADDR_W-1:0]),
        .wr_data (pre_wr_data),
        .rd_addr (tab_rd_addr),
        .rd_data (pre_rd)
    );

    lzwst_ram #(
        .WIDTH (lzwst_pkg::BYTE_W),
        .DEPTH (lzwst_pkg::MAX_LEN)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (depth_reg[lzwst_pkg::STACK_AW-1:0]),
        .wr_data (suf_rd),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd)
    );

    // Sequence commands, chain walk and byte pop
    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        q_pop       = 1'b0;
        load        = 1'b0;
        o_new_code  = '0;
        o_byte      = '0;
        o_pos       = '0;
        o_last      = 1'b1;
        o_status    = lzwst_pkg::STATUS_OK;
        suf_wr_en   = 1'b0;
        suf_wr_addr = q_cmd.new_code[lzwst_pkg::ADDR_W-1:0];
        suf_wr_data = q_cmd.value;
        pre_wr_en   = 1'b0;
        pre_wr_data = '0;
        stk_wr_en   = 1'b0;
        stk_rd_addr = ptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cmd.kind == lzwst_pkg::KIND_READ)
                    begin
                        q_pop      = 1'b1;
                        depth_next = '0;
                        state_next = S_WALK;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        load  = 1'b1;
                        unique case (q_cmd.kind)
                            lzwst_pkg::KIND_ROOT:
                            begin
                                suf_wr_en  = 1'b1;
                                pre_wr_en  = 1'b1;
                                o_new_code = q_cmd.new_code;
                            end
                            lzwst_pkg::KIND_EXTEND:
                            begin
                                suf_wr_en   = 1'b1;
                                suf_wr_data = '0;
                                pre_wr_en   = 1'b1;
                                pre_wr_data = {1'b1, q_cmd.code};
                                o_new_code  = q_cmd.new_code;
                            end
                            lzwst_pkg::KIND_SUFFIX:
                            begin
                                suf_wr_en   = 1'b1;
                                suf_wr_addr = q_cmd.code[lzwst_pkg::ADDR_W-1:0];
                            end
                            lzwst_pkg::KIND_ERR_FULL:
                            begin
                                o_status = lzwst_pkg::STATUS_FULL;
                            end
                            default:
                            begin
                                o_status = lzwst_pkg::STATUS_UNKNOWN;
                            end
                        endcase
                    end
                end
            end
            S_WALK:
            begin
                if (depth_reg == lzwst_pkg::DEPTH_W'(lzwst_pkg::MAX_LEN))
                begin
                    state_next = S_LONG;
                end
                else
                begin
                    stk_wr_en  = 1'b1;
                    depth_next = depth_reg + lzwst_pkg::DEPTH_W'(1);
                    if (!pre_rd[lzwst_pkg::CODE_W])
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                stk_rd_addr = depth_m1[lzwst_pkg::STACK_AW-1:0];
                ptr_next    = depth_m1[lzwst_pkg::STACK_AW-1:0];
                pos_next    = '0;
                state_next  = S_POP;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    load   = 1'b1;
                    o_byte = stk_rd;
                    o_pos  = lzwst_pkg::POS_W'(pos_reg);
                    o_last = ptr_reg == '0;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next    = ptr_reg - lzwst_pkg::STACK_AW'(1);
                        pos_next    = pos_reg + lzwst_pkg::STACK_AW'(1);
                        stk_rd_addr = ptr_reg - lzwst_pkg::STACK_AW'(1);
                    end
                end
            end
            S_LONG:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    o_status   = lzwst_pkg::STATUS_TOO_LONG;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a stalled result, drop a taken one
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            new_code_reg <= o_new_code;
            byte_reg     <= o_byte;
            pos_out_reg  <= o_pos;
            last_reg     <= o_last;
            status_reg   <= o_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_code  = new_code_reg;
    assign byte_out  = byte_reg;
    assign position  = pos_out_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // Checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= lzwst_pkg::DEPTH_W'(lzwst_pkg::MAX_LEN))
        else $error("walk depth beyond string limit");

    a_pop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (lzwst_pkg::DEPTH_W'(ptr_reg) < depth_reg))
        else $error("pop pointer outside stacked bytes");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != lzwst_pkg::STATUS_OK)
        |-> (last_reg && byte_reg == '0 && pos_out_reg == '0))
        else $error("error result with payload");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command taken from empty queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load)
        else $error("stalled result overwritten");

endmodule

FILE: sv/lzw_string_table_unit.sv
// ============================================================================
// lzw_string_table_unit: LZW string table with prefix-chain string readout
// Results: a root, extend, set-suffix or error request passes through the
// command queue and is loaded into the output register when the back end is
// idle and the output is free. A read walks its prefix chain onto the LIFO, one
// chain entry per cycle over the single table read port, then pops one byte per
// cycle while the output is not stalled. Non-read requests flow one per cycle while nothing stalls.
// Reset clears the code count, queue and output valid; tables are not cleared.
// ============================================================================
module lzw_string_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lzwst_pkg::MODE_W-1:0]    mode,
    input  logic [lzwst_pkg::CODE_W-1:0]    code,
    input  logic [lzwst_pkg::BYTE_W-1:0]    byte_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lzwst_pkg::CODE_W-1:0]    new_code,
    output logic [lzwst_pkg::BYTE_W-1:0]    byte_out,
    output logic [lzwst_pkg::POS_W-1:0]     position,
    output logic                            last,
    output logic [lzwst_pkg::STATUS_W-1:0]  status
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    lzwst_pkg::cmd_t push_cmd;
    lzwst_pkg::cmd_t head_cmd;

    // Classify requests and assign codes
    lzwst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .code       (code),
        .byte_value (byte_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Buffer classified commands
    lzwst_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .pop     (q_pop),
        .cmd_out (head_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Execute commands against the tables
    lzwst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_code  (new_code),
        .byte_out  (byte_out),
        .position  (position),
        .last      (last),
        .status    (status)
    );

endmodule

FILE: dv/tb_lzw_string_table_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_lzw_string_table_unit: self-checking bench for the LZW string table
// Drives root, extend, set-suffix and read requests with random gaps, keeps
// a shadow string table to work out every result, and checks each result
// in order: opening rows, a 65-entry chain, then random traffic.
// ============================================================================
module tb_lzw_string_table_unit;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_PCT     = 12;
    localparam int RANDOM_ITEMS = 270;
    localparam int CHAIN_TOP    = 66;

    typedef struct packed {
        logic [lzwst_pkg::CODE_W-1:0]   new_code;
        logic [lzwst_pkg::BYTE_W-1:0]   byte_out;
        logic [lzwst_pkg::POS_W-1:0]    position;
        logic                           last;
        logic [lzwst_pkg::STATUS_W-1:0] status;
    } table_result_t;

    // One opening request; typed rows carry their single result inline
    typedef struct packed {
        logic [lzwst_pkg::MODE_W-1:0]   mode;
        logic [lzwst_pkg::CODE_W-1:0]   code;
        logic [lzwst_pkg::BYTE_W-1:0]   value;
        logic                           typed;
        logic [lzwst_pkg::CODE_W-1:0]   exp_code;
        logic [lzwst_pkg::STATUS_W-1:0] exp_status;
    } opening_row_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [lzwst_pkg::MODE_W-1:0]   mode       = lzwst_pkg::MODE_ROOT;
    logic [lzwst_pkg::CODE_W-1:0]   code       = '0;
    logic [lzwst_pkg::BYTE_W-1:0]   byte_value = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic [lzwst_pkg::CODE_W-1:0]   new_code;
    logic [lzwst_pkg::BYTE_W-1:0]   byte_out;
    logic [lzwst_pkg::POS_W-1:0]    position;
    logic                           last;
    logic [lzwst_pkg::STATUS_W-1:0] status;

    // Shadow string table
    logic [lzwst_pkg::BYTE_W-1:0]  suffix_mem [lzwst_pkg::TABLE_DEPTH];
    logic [lzwst_pkg::LINK_W-1:0]  link_mem   [lzwst_pkg::TABLE_DEPTH];
    logic [lzwst_pkg::COUNT_W-1:0] table_count = '0;

    table_result_t pending_results [$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            calm        = 1'b0;

    opening_row_t opening_rows [0:17] = '{
        '{lzwst_pkg::MODE_READ,   12'd0,    8'h00, 1'b1, 12'd0, lzwst_pkg::STATUS_UNKNOWN},
        '{lzwst_pkg::MODE_EXTEND, 12'd4095, 8'h00, 1'b1, 12'd0, lzwst_pkg::STATUS_UNKNOWN},
        '{lzwst_pkg::MODE_SUFFIX, 12'd0,    8'h33, 1'b1, 12'd0, lzwst_pkg::STATUS_UNKNOWN},
        '{lzwst_pkg::MODE_ROOT,   12'd0,    8'h00, 1'b1, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_ROOT,   12'd0,    8'hFF, 1'b1, 12'd1, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_ROOT,   12'd4095, 8'hA5, 1'b1, 12'd2, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd0,    8'hFF, 1'b0, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd1,    8'h00, 1'b0, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_EXTEND, 12'd1,    8'hFF, 1'b1, 12'd3, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_SUFFIX, 12'd3,    8'h5A, 1'b1, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_EXTEND, 12'd3,    8'h00, 1'b1, 12'd4, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_SUFFIX, 12'd4,    8'h80, 1'b1, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd4,    8'h00, 1'b0, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd3,    8'h00, 1'b0, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_SUFFIX, 12'd0,    8'h7F, 1'b1, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd2,    8'h00, 1'b0, 12'd0, lzwst_pkg::STATUS_OK},
        '{lzwst_pkg::MODE_READ,   12'd5,    8'h00, 1'b1, 12'd0, lzwst_pkg::STATUS_UNKNOWN},
        '{lzwst_pkg::MODE_EXTEND, 12'd5,    8'h00, 1'b1, 12'd0, lzwst_pkg::STATUS_UNKNOWN}
    };

    lzw_string_table_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .code       (code),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .new_code   (new_code),
        .byte_out   (byte_out),
        .position   (position),
        .last       (last),
        .status     (status)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Update the shadow table for one request and queue the strings it yields
    function automatic void predict_table(input logic [lzwst_pkg::MODE_W-1:0] m,
                                          input logic [lzwst_pkg::CODE_W-1:0] c,
                                          input logic [lzwst_pkg::BYTE_W-1:0] b);
        table_result_t                r;
        logic [lzwst_pkg::BYTE_W-1:0] walk [lzwst_pkg::MAX_LEN];
        logic [lzwst_pkg::CODE_W-1:0] cur;
        int                           depth;
        bit                           at_root;
        r      = '0;
        r.last = 1'b1;
        if (m != lzwst_pkg::MODE_ROOT && {1'b0, c} >= table_count)
        begin
            r.status = lzwst_pkg::STATUS_UNKNOWN;
            pending_results.push_back(r);
            return;
        end
        case (m)
            lzwst_pkg::MODE_ROOT, lzwst_pkg::MODE_EXTEND:
            begin
                if (table_count >= lzwst_pkg::TABLE_DEPTH)
                    r.status = lzwst_pkg::STATUS_FULL;
                else
                begin
                    suffix_mem[table_count[lzwst_pkg::ADDR_W-1:0]] =
                        (m == lzwst_pkg::MODE_ROOT) ? b : '0;
                    link_mem[table_count[lzwst_pkg::ADDR_W-1:0]] =
                        (m == lzwst_pkg::MODE_ROOT) ? '0 : {1'b1, c};
                    r.new_code  = table_count[lzwst_pkg::CODE_W-1:0];
                    table_count = table_count + lzwst_pkg::COUNT_W'(1);
                end
                pending_results.push_back(r);
            end
            lzwst_pkg::MODE_SUFFIX:
            begin
                suffix_mem[c] = b;
                pending_results.push_back(r);
            end
            default:
            begin
                // walk toward the root, collecting bytes last to first
                cur     = c;
                depth   = 0;
                at_root = 1'b0;
                while (!at_root)
                begin
                    if (depth >= lzwst_pkg::MAX_LEN)
                    begin
                        r.status = lzwst_pkg::STATUS_TOO_LONG;
                        pending_results.push_back(r);
                        return;
                    end
                    walk[depth] = suffix_mem[cur];
                    depth++;
                    if (!link_mem[cur][lzwst_pkg::CODE_W])
                        at_root = 1'b1;
                    else
                        cur = link_mem[cur][lzwst_pkg::CODE_W-1:0];
                end
                for (int i = 0; i < depth; i++)
                begin
                    r          = '0;
                    r.byte_out = walk[depth - 1 - i];
                    r.position = i[lzwst_pkg::POS_W-1:0];
                    r.last     = (i == depth - 1);
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    // Pick an assigned code, often one of the newest so chains grow deep
    function automatic logic [lzwst_pkg::CODE_W-1:0] pick_code();
        int top;
        top = int'(table_count) - 1;
        if ($urandom_range(1) == 0)
            return lzwst_pkg::CODE_W'($urandom_range(top, (top > 7) ? top - 7 : 0));
        return lzwst_pkg::CODE_W'($urandom_range(top, 0));
    endfunction

    // Send one request, waiting out random gaps and the stall
    task automatic issue_request(input logic [lzwst_pkg::MODE_W-1:0] m,
                                 input logic [lzwst_pkg::CODE_W-1:0] c,
                                 input logic [lzwst_pkg::BYTE_W-1:0] b,
                                 input bit                           typed,
                                 input table_result_t                typed_result);
        int mark;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        code       <= c;
        byte_value <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mark = pending_results.size();
        predict_table(m, c, b);
        if (typed)
        begin
            while (pending_results.size() > mark)
                void'(pending_results.pop_back());
            pending_results.push_back(typed_result);
        end
    endtask

    // Stall results at random on the receiving side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result code=%0d byte=%0h pos=%0d st=%0d",
                                     new_code, byte_out, position, status));
            else
            begin
                want = pending_results.pop_front();
                if (new_code !== want.new_code || byte_out !== want.byte_out ||
                    position !== want.position || last !== want.last ||
                    status !== want.status)
                    flag_error($sformatf(
                        "got code=%0d byte=%0h pos=%0d last=%0b st=%0d, want %0d %0h %0d %0b %0d",
                        new_code, byte_out, position, last, status, want.new_code,
                        want.byte_out, want.position, want.last, want.status));
            end
        end
    end

    // Hold a hard limit on the run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        table_result_t                typed_result;
        logic [lzwst_pkg::MODE_W-1:0] m;
        logic [lzwst_pkg::CODE_W-1:0] c;
        int                           pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening rows: empty table, extremes, rewrites, unassigned codes
        foreach (opening_rows[i])
        begin
            typed_result          = '0;
            typed_result.new_code = opening_rows[i].exp_code;
            typed_result.status   = opening_rows[i].exp_status;
            typed_result.last     = 1'b1;
            issue_request(opening_rows[i].mode, opening_rows[i].code,
                          opening_rows[i].value, opening_rows[i].typed, typed_result);
        end

        // grow one chain to 65 bytes: read 64 bytes, the longest legal read, then one too long
        for (int k = 5; k <= CHAIN_TOP; k++)
            issue_request(lzwst_pkg::MODE_EXTEND, lzwst_pkg::CODE_W'(k - 1), 8'h00,
                          1'b0, '0);
        issue_request(lzwst_pkg::MODE_SUFFIX, lzwst_pkg::CODE_W'(CHAIN_TOP - 1), 8'hC3,
                      1'b0, '0);
        issue_request(lzwst_pkg::MODE_READ, lzwst_pkg::CODE_W'(CHAIN_TOP - 1), 8'h00,
                      1'b0, '0);
        typed_result        = '0;
        typed_result.status = lzwst_pkg::STATUS_TOO_LONG;
        typed_result.last   = 1'b1;
        issue_request(lzwst_pkg::MODE_READ, lzwst_pkg::CODE_W'(CHAIN_TOP), 8'h00,
                      1'b1, typed_result);

        // random traffic, mostly well-formed, with a stretch of no idling
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 150 && n < 230);
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                m = lzwst_pkg::MODE_ROOT;
                c = lzwst_pkg::CODE_W'($urandom);
            end
            else if (pick < 92)
            begin
                m = (pick < 40) ? lzwst_pkg::MODE_EXTEND :
                    (pick < 55) ? lzwst_pkg::MODE_SUFFIX : lzwst_pkg::MODE_READ;
                c = pick_code();
            end
            else
            begin
                m = lzwst_pkg::MODE_W'($urandom_range(3, 1));
                c = lzwst_pkg::CODE_W'($urandom_range(lzwst_pkg::TABLE_DEPTH - 1,
                                                      int'(table_count)));
            end
            issue_request(m, c, lzwst_pkg::BYTE_W'($urandom), 1'b0, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
